// ===== sv/srpg_pkg.sv =====
package srpg_pkg;

    localparam int CFG_ADDR_BITS = 2;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_SLOW_HALF_PERIOD = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_FAST_HALF_PERIOD = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RAMP_STEPS       = 2'd2;

    localparam int SLOW_HALF_PERIOD_RESET = 2000;
    localparam int FAST_HALF_PERIOD_RESET = 500;
    localparam int RAMP_STEPS_RESET       = 200;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic sel;
        logic mul;
        logic fin;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic need_calc;
        logic flat;
        logic div_busy;
    } status_t;

endpackage

// ===== sv/srpg_div.sv =====
module srpg_div
#(
    parameter int STEP_BITS   = 24,
    parameter int PERIOD_BITS = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic [STEP_BITS+PERIOD_BITS-1:0] numer,
    input  logic [STEP_BITS-1:0]             denom,
    output logic                             busy,
    output logic [PERIOD_BITS-1:0]           quot
);

    // The quotient is known to fit in PERIOD_BITS bits because the numerator is
    // below denom shifted left by PERIOD_BITS, so only that many steps are run.
    localparam int CNT_BITS = $clog2(PERIOD_BITS + 1);

    logic [STEP_BITS-1:0]   rem_reg;
    logic [STEP_BITS-1:0]   rem_next;
    logic [PERIOD_BITS-1:0] sh_reg;
    logic [PERIOD_BITS-1:0] sh_next;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic [CNT_BITS-1:0]    cnt_next;
    logic [STEP_BITS:0]     trial;
    logic [STEP_BITS:0]     trial_sub;
    logic                   ge;

    assign trial     = {rem_reg, sh_reg[PERIOD_BITS-1]};
    assign ge        = trial >= {1'b0, denom};
    assign trial_sub = trial - {1'b0, denom};
    assign busy      = cnt_reg != '0;
    assign quot      = sh_reg;

    always_comb
    begin
        rem_next = rem_reg;
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            rem_next = numer[STEP_BITS+PERIOD_BITS-1:PERIOD_BITS];
            sh_next  = numer[PERIOD_BITS-1:0];
            cnt_next = CNT_BITS'(PERIOD_BITS);
        end
        else if (busy)
        begin
            rem_next = ge ? trial_sub[STEP_BITS-1:0] : trial[STEP_BITS-1:0];
            sh_next  = {sh_reg[PERIOD_BITS-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

endmodule

// ===== sv/srpg_dp.sv =====
module srpg_dp
import srpg_pkg::*;
#(
    parameter int STEP_BITS   = 24,
    parameter int PERIOD_BITS = 16,
    parameter int CFG_BITS    = 24
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output status_t                  st,
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_BITS-1:0]      cfg_wdata,
    input  logic                     mode,
    input  logic [STEP_BITS-1:0]     step_total,
    input  logic                     direction,
    output logic                     pulse,
    output logic                     direction_level,
    output logic                     busy_res,
    output logic                     done_res,
    output logic [PERIOD_BITS-1:0]   present_half_period
);

    logic [PERIOD_BITS-1:0] slow_reg;
    logic [PERIOD_BITS-1:0] fast_reg;
    logic [STEP_BITS-1:0]   ramp_reg;

    logic [STEP_BITS-1:0]   steps_done_reg;
    logic [STEP_BITS-1:0]   steps_done_next;
    logic [STEP_BITS-1:0]   steps_in_move_reg;
    logic [STEP_BITS-1:0]   steps_in_move_next;
    logic [STEP_BITS-1:0]   ramp_length_reg;
    logic [STEP_BITS-1:0]   ramp_length_next;
    logic [PERIOD_BITS-1:0] half_reg;
    logic [PERIOD_BITS-1:0] half_next;
    logic [PERIOD_BITS-1:0] tick_reg;
    logic [PERIOD_BITS-1:0] tick_next;
    logic                   pulse_reg;
    logic                   pulse_next;
    logic                   moving_reg;
    logic                   moving_next;
    logic                   dir_reg;
    logic                   dir_next;
    logic                   done_reg;
    logic                   done_next;

    logic [STEP_BITS-1:0]   j_reg;
    logic [PERIOD_BITS-1:0] base_reg;
    logic [PERIOD_BITS-1:0] diff_reg;
    logic                   dec_reg;

    logic                   pulse_out_reg;
    logic                   dir_out_reg;
    logic                   busy_out_reg;
    logic                   done_out_reg;
    logic [PERIOD_BITS-1:0] half_out_reg;

    logic [STEP_BITS-1:0]   half_total;
    logic [PERIOD_BITS-1:0] tick_inc;
    logic                   tick_hit;
    logic [STEP_BITS-1:0]   steps_inc;
    logic                   last_step;

    logic [STEP_BITS-1:0]   n_minus_r;
    logic                   rise;
    logic                   fall;
    logic [PERIOD_BITS-1:0] seg_from;
    logic [PERIOD_BITS-1:0] seg_to;

    logic [STEP_BITS+PERIOD_BITS-1:0] prod;
    logic                             div_busy;
    logic [PERIOD_BITS-1:0]           quot;

    assign half_total = step_total >> 1;
    assign tick_inc   = tick_reg + 1'b1;
    assign tick_hit   = tick_inc >= half_reg;
    assign steps_inc  = steps_done_reg + 1'b1;
    assign last_step  = steps_inc >= steps_in_move_reg;

    assign n_minus_r = steps_in_move_reg - ramp_length_reg;
    assign rise      = steps_done_reg < ramp_length_reg;
    assign fall      = steps_done_reg > n_minus_r;
    assign seg_from  = rise ? slow_reg : fast_reg;
    assign seg_to    = rise ? fast_reg : slow_reg;

    assign st.need_calc = mode ? (step_total != '0)
                               : (moving_reg && tick_hit && !pulse_reg && !last_step);
    assign st.flat      = !rise && !fall;
    assign st.div_busy  = div_busy;

    assign prod = {{PERIOD_BITS{1'b0}}, j_reg} * {{STEP_BITS{1'b0}}, diff_reg};

    srpg_div
    #(
        .STEP_BITS   (STEP_BITS),
        .PERIOD_BITS (PERIOD_BITS)
    )
    u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (cmd.mul),
        .numer (prod),
        .denom (ramp_length_reg),
        .busy  (div_busy),
        .quot  (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_reg <= PERIOD_BITS'(SLOW_HALF_PERIOD_RESET);
            fast_reg <= PERIOD_BITS'(FAST_HALF_PERIOD_RESET);
            ramp_reg <= STEP_BITS'(RAMP_STEPS_RESET);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_SLOW_HALF_PERIOD: slow_reg <= cfg_wdata[PERIOD_BITS-1:0];
                CFG_FAST_HALF_PERIOD: fast_reg <= cfg_wdata[PERIOD_BITS-1:0];
                CFG_RAMP_STEPS:       ramp_reg <= cfg_wdata[STEP_BITS-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        steps_done_next    = steps_done_reg;
        steps_in_move_next = steps_in_move_reg;
        ramp_length_next   = ramp_length_reg;
        half_next          = half_reg;
        tick_next          = tick_reg;
        pulse_next         = pulse_reg;
        moving_next        = moving_reg;
        dir_next           = dir_reg;
        done_next          = done_reg;
        if (cmd.accept)
        begin
            done_next = 1'b0;
            if (mode)
            begin
                dir_next           = direction;
                steps_in_move_next = step_total;
                ramp_length_next   = (half_total > ramp_reg) ? ramp_reg : half_total;
                steps_done_next    = '0;
                tick_next          = '0;
                moving_next        = step_total != '0;
                pulse_next         = step_total != '0;
            end
            else if (moving_reg)
            begin
                tick_next = tick_inc;
                if (tick_hit)
                begin
                    tick_next = '0;
                    if (pulse_reg)
                    begin
                        pulse_next = 1'b0;
                    end
                    else
                    begin
                        steps_done_next = steps_inc;
                        if (last_step)
                        begin
                            moving_next = 1'b0;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            pulse_next = 1'b1;
                        end
                    end
                end
            end
        end
        else if (cmd.sel && st.flat)
        begin
            half_next = fast_reg;
        end
        else if (cmd.fin)
        begin
            half_next = dec_reg ? (base_reg - quot) : (base_reg + quot);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_done_reg    <= '0;
            steps_in_move_reg <= '0;
            ramp_length_reg   <= '0;
            half_reg          <= '0;
            tick_reg          <= '0;
            pulse_reg         <= 1'b0;
            moving_reg        <= 1'b0;
            dir_reg           <= 1'b0;
            done_reg          <= 1'b0;
        end
        else
        begin
            steps_done_reg    <= steps_done_next;
            steps_in_move_reg <= steps_in_move_next;
            ramp_length_reg   <= ramp_length_next;
            half_reg          <= half_next;
            tick_reg          <= tick_next;
            pulse_reg         <= pulse_next;
            moving_reg        <= moving_next;
            dir_reg           <= dir_next;
            done_reg          <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sel)
        begin
            j_reg    <= rise ? steps_done_reg : (steps_done_reg - n_minus_r);
            base_reg <= seg_from;
            dec_reg  <= seg_to < seg_from;
            diff_reg <= (seg_to < seg_from) ? (seg_from - seg_to) : (seg_to - seg_from);
        end
        if (cmd.emit)
        begin
            pulse_out_reg <= pulse_reg;
            dir_out_reg   <= dir_reg;
            busy_out_reg  <= moving_reg;
            done_out_reg  <= done_reg;
            half_out_reg  <= half_reg;
        end
    end

    assign pulse               = pulse_out_reg;
    assign direction_level     = dir_out_reg;
    assign busy_res            = busy_out_reg;
    assign done_res            = done_out_reg;
    assign present_half_period = half_out_reg;

endmodule

// ===== sv/srpg_ctrl.sv =====
module srpg_ctrl
import srpg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = st.need_calc ? ST_SEL : ST_EMIT;
                end
            end
            ST_SEL:
            begin
                state_next = st.flat ? ST_EMIT : ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!st.div_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_SEL:
            begin
                cmd.sel = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            ST_DIV:
            begin
                cmd.fin = !st.div_busy;
            end
            ST_EMIT:
            begin
                cmd.emit = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== sv/stepper_ramp_pulse_generator.sv =====
// Trapezoidal ramp step pulse generator. A start beat (mode 1) loads a move of
// step_total steps and a direction; every tick beat (mode 0) stands for one
// microsecond and returns one result beat with the step and direction pin
// levels, the busy and done flags and the half-period of the current step. The
// half-period ramps linearly from slow to fast over the first ramp steps, holds
// at fast, and ramps back over the last ones; the ramp is the smaller of
// ramp_steps and half the move. A tick that does not begin a new step goes
// from the idle state straight to the emit state. A start beat or a tick that
// begins a new step passes through the select state when that step lies between
// the ramps, and through the select, multiply and divide states when it lies on
// a ramp, for the interpolation: one multiply, then a restoring divider that
// yields one quotient bit per cycle. A new input beat is taken while the
// previous result still waits in the output register; a result that is ready
// while the one before it has not been taken waits until out_ready is high.
module stepper_ramp_pulse_generator
import srpg_pkg::*;
#(
    parameter int STEP_BITS   = 24,
    parameter int PERIOD_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [((STEP_BITS > PERIOD_BITS) ? STEP_BITS : PERIOD_BITS)-1:0] cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     mode,
    input  logic [STEP_BITS-1:0]     step_total,
    input  logic                     direction,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     pulse,
    output logic                     direction_level,
    output logic                     busy_res,
    output logic                     done_res,
    output logic [PERIOD_BITS-1:0]   present_half_period
);

    localparam int CFG_BITS = (STEP_BITS > PERIOD_BITS) ? STEP_BITS : PERIOD_BITS;

    cmd_t    cmd;
    status_t st;

    srpg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    srpg_dp
    #(
        .STEP_BITS   (STEP_BITS),
        .PERIOD_BITS (PERIOD_BITS),
        .CFG_BITS    (CFG_BITS)
    )
    u_dp
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .st                  (st),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_addr            (cfg_addr),
        .cfg_wdata           (cfg_wdata),
        .mode                (mode),
        .step_total          (step_total),
        .direction           (direction),
        .pulse               (pulse),
        .direction_level     (direction_level),
        .busy_res            (busy_res),
        .done_res            (done_res),
        .present_half_period (present_half_period)
    );

    // Only one beat is in flight at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a beat was in flight");

    // The move that just finished is never reported as still running.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> !busy_res)
        else $error("done reported on a busy result");

    // With no move running, the step pin rests low.
    a_idle_pin_low: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !busy_res) |-> !pulse)
        else $error("step pin high while idle");

endmodule
